[rtl/arpfr_pkg.sv]
// Package with the shared types, constants and frame assembly for the ARP responder.
`timescale 1ns / 1ps

package arpfr_pkg;

  // Configuration register indexes.
  localparam logic REG_MY_MAC = 1'b0;
  localparam logic REG_MY_IP  = 1'b1;

  // Input item kinds carried on the input tuser.
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 160;
  localparam int unsigned CFG_W     = 48;

  // Fixed field values of ARP over Ethernet.
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] HTYPE_ETH      = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_ETH       = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] OPER_REQUEST   = 16'd1;
  localparam logic [15:0] OPER_REPLY     = 16'd2;
  localparam logic [7:0]  KEEP_FULL      = 8'hFF;
  localparam logic [7:0]  KEEP_LAST_BEAT = 8'h03;

  // Beat counter values: captures end at beat 5, the count holds at 6.
  localparam logic [2:0] BEAT_SAT   = 3'd6;
  // Job steps: step 0 is the binding result, steps 1 to 6 are the frame beats.
  localparam logic [2:0] STEP_BIND  = 3'd0;
  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_FINAL = 3'd6;

  // Per-frame fields of an outgoing ARP frame; our own addresses come from config.
  typedef struct packed {
    logic [47:0] da;
    logic [15:0] etype;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [7:0]  hlen;
    logic [7:0]  plen;
    logic [15:0] oper;
    logic [47:0] tha;
    logic [31:0] tpa;
  } frame_desc_t;

  // Build one 64-bit little-endian beat (0 to 5) of the 48-byte frame.
  function automatic logic [63:0] build_beat(frame_desc_t desc, logic [47:0] mac,
                                             logic [31:0] ip, logic [2:0] idx);
    logic [383:0] frame;
    logic [5:0]   k;
    logic [63:0]  beat;
    // Network order: frame byte 0 is the top byte of the vector.
    frame = {desc.da, mac, desc.etype, desc.htype, desc.ptype, desc.hlen, desc.plen,
             desc.oper, mac, ip, desc.tha, desc.tpa, 48'h0};
    beat  = '0;
    for (int i = 0; i < 8; i++) begin
      k = {idx, 3'(i)};
      beat[8*i +: 8] = frame[383 - 8*k -: 8];
    end
    return beat;
  endfunction

endpackage

[rtl/arp_frame_responder_unit.sv]
// Top level of the ARP responder: frame parser, reply and request generator, output register.
`timescale 1ns / 1ps

// The block parses ARP frames arriving as 64-bit little-endian beats and takes one beat per
// clock while no job is running. The last beat of a frame starts a job that sends the sender's
// address binding (tuser 1) and, for an ARP request aimed at our IP, a six-beat reply; a
// resolve item (tuser 1 on the input) starts a job that sends a six-beat broadcast ARP request.
// A job sends one result beat per clock, unless the output stalls, through a single output
// register; while a job runs, every input beat is held off until the job's final beat moves
// into the output register, and the next beat can be taken in that same cycle. The first
// result of an accepted input beat goes to the job registers, then to the output register.
// The user must write my_mac and my_ip only while the block is idle; it is not enforced.
module arp_frame_responder_unit
  import arpfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // rx_data[63:0], resolve_ip[95:64]
  input  logic                 s_axis_tlast,   // rx_last
  input  logic                 s_axis_tuser,   // kind
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tx_data[63:0], tx_keep[71:64], bind_mac[119:72], bind_ip[151:120], run_last[152], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast,   // tx_frame_last
  output logic                 m_axis_tuser    // out_kind
);

  // Configuration registers.
  logic [47:0] my_mac_q;
  logic [31:0] my_ip_q;

  // Parser state.
  logic [2:0]  beat_index_q, beat_index_d;
  logic [47:0] remote_mac_q, remote_mac_d;
  logic [15:0] ethertype_q, ethertype_d;
  logic [15:0] hw_type_q, hw_type_d;
  logic [15:0] proto_type_q, proto_type_d;
  logic [7:0]  hw_len_q, hw_len_d;
  logic [7:0]  proto_len_q, proto_len_d;
  logic [15:0] opcode_q, opcode_d;
  logic [47:0] sender_mac_q, sender_mac_d;
  logic [31:0] sender_ip_q, sender_ip_d;
  logic [31:0] target_ip_q, target_ip_d;

  // Job state.
  logic        job_valid_q;
  logic        job_frame_q;
  logic [2:0]  step_q;
  frame_desc_t desc_q, desc_d;
  logic [47:0] bind_mac_q;
  logic [31:0] bind_ip_q;

  // Output register.
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_tdata_q, out_tdata_d;
  logic                 out_tlast_q, out_tlast_d;
  logic                 out_tuser_q, out_tuser_d;

  logic [63:0] rx_data;
  logic [31:0] resolve_ip;
  logic        in_fire;
  logic        out_adv;
  logic        gen_fire;
  logic        job_final;
  logic        job_start;
  logic        reply;

  assign rx_data    = s_axis_tdata[63:0];
  assign resolve_ip = s_axis_tdata[95:64];

  // Handshake control: the output register moves when empty or taken.
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign gen_fire      = job_valid_q && out_adv;
  assign job_final     = step_q == (job_frame_q ? STEP_FINAL : STEP_BIND);
  assign s_axis_tready = !job_valid_q || (gen_fire && job_final);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign job_start     = in_fire && (s_axis_tuser || s_axis_tlast);

  // Field capture for the current beat; fields are big-endian within the frame.
  always_comb begin
    remote_mac_d = remote_mac_q;
    ethertype_d  = ethertype_q;
    hw_type_d    = hw_type_q;
    proto_type_d = proto_type_q;
    hw_len_d     = hw_len_q;
    proto_len_d  = proto_len_q;
    opcode_d     = opcode_q;
    sender_mac_d = sender_mac_q;
    sender_ip_d  = sender_ip_q;
    target_ip_d  = target_ip_q;
    unique case (beat_index_q)
      3'd0: begin
        remote_mac_d[47:32] = {rx_data[55:48], rx_data[63:56]};
      end
      3'd1: begin
        remote_mac_d[31:0] = {rx_data[7:0], rx_data[15:8], rx_data[23:16], rx_data[31:24]};
        ethertype_d        = {rx_data[39:32], rx_data[47:40]};
        hw_type_d          = {rx_data[55:48], rx_data[63:56]};
      end
      3'd2: begin
        proto_type_d        = {rx_data[7:0], rx_data[15:8]};
        hw_len_d            = rx_data[23:16];
        proto_len_d         = rx_data[31:24];
        opcode_d            = {rx_data[39:32], rx_data[47:40]};
        sender_mac_d[47:32] = {rx_data[55:48], rx_data[63:56]};
      end
      3'd3: begin
        sender_mac_d[31:0] = {rx_data[7:0], rx_data[15:8], rx_data[23:16], rx_data[31:24]};
        sender_ip_d        = {rx_data[39:32], rx_data[47:40], rx_data[55:48], rx_data[63:56]};
      end
      3'd4: begin
        target_ip_d[31:16] = {rx_data[55:48], rx_data[63:56]};
      end
      3'd5: begin
        target_ip_d[15:0] = {rx_data[7:0], rx_data[15:8]};
      end
      default: begin
      end
    endcase

    if (s_axis_tlast) begin
      beat_index_d = '0;
    end else if (beat_index_q < BEAT_SAT) begin
      beat_index_d = beat_index_q + 3'd1;
    end else begin
      beat_index_d = beat_index_q;
    end
  end

  // Reply decision and the descriptor of the frame to send.
  assign reply = (opcode_d == OPER_REQUEST) && (target_ip_d == my_ip_q);

  always_comb begin
    if (s_axis_tuser) begin
      desc_d.da    = MAC_BCAST;
      desc_d.etype = ETYPE_ARP;
      desc_d.htype = HTYPE_ETH;
      desc_d.ptype = PTYPE_IPV4;
      desc_d.hlen  = HLEN_ETH;
      desc_d.plen  = PLEN_IPV4;
      desc_d.oper  = OPER_REQUEST;
      desc_d.tha   = '0;
      desc_d.tpa   = resolve_ip;
    end else begin
      desc_d.da    = remote_mac_d;
      desc_d.etype = ethertype_d;
      desc_d.htype = hw_type_d;
      desc_d.ptype = proto_type_d;
      desc_d.hlen  = hw_len_d;
      desc_d.plen  = proto_len_d;
      desc_d.oper  = OPER_REPLY;
      desc_d.tha   = sender_mac_d;
      desc_d.tpa   = sender_ip_d;
    end
  end

  // Result beat for the current job step.
  always_comb begin
    logic [63:0] tx_data;
    logic [7:0]  tx_keep;
    logic [47:0] b_mac;
    logic [31:0] b_ip;
    logic        run_last;
    tx_data  = '0;
    tx_keep  = '0;
    b_mac    = '0;
    b_ip     = '0;
    run_last = 1'b0;
    out_tlast_d = 1'b0;
    out_tuser_d = 1'b0;
    if (step_q == STEP_BIND) begin
      out_tuser_d = 1'b1;
      b_mac       = bind_mac_q;
      b_ip        = bind_ip_q;
      run_last    = !job_frame_q;
    end else begin
      tx_data     = build_beat(desc_q, my_mac_q, my_ip_q, step_q - STEP_FIRST);
      tx_keep     = (step_q == STEP_FINAL) ? KEEP_LAST_BEAT : KEEP_FULL;
      out_tlast_d = step_q == STEP_FINAL;
      run_last    = step_q == STEP_FINAL;
    end
    out_tdata_d = {7'b0, run_last, b_ip, b_mac, tx_keep, tx_data};
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_mac_q <= '0;
      my_ip_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MY_MAC: my_mac_q <= cfg_wdata_i;
        REG_MY_IP:  my_ip_q  <= cfg_wdata_i[31:0];
        default: begin
        end
      endcase
    end
  end

  // Parser state, updated on every accepted frame beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_index_q <= '0;
      remote_mac_q <= '0;
      ethertype_q  <= '0;
      hw_type_q    <= '0;
      proto_type_q <= '0;
      hw_len_q     <= '0;
      proto_len_q  <= '0;
      opcode_q     <= '0;
      sender_mac_q <= '0;
      sender_ip_q  <= '0;
      target_ip_q  <= '0;
    end else if (in_fire && !s_axis_tuser) begin
      beat_index_q <= beat_index_d;
      remote_mac_q <= remote_mac_d;
      ethertype_q  <= ethertype_d;
      hw_type_q    <= hw_type_d;
      proto_type_q <= proto_type_d;
      hw_len_q     <= hw_len_d;
      proto_len_q  <= proto_len_d;
      opcode_q     <= opcode_d;
      sender_mac_q <= sender_mac_d;
      sender_ip_q  <= sender_ip_d;
      target_ip_q  <= target_ip_d;
    end
  end

  // Job control: load on a frame end or a resolve item, step once per output beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_frame_q <= 1'b0;
      step_q      <= STEP_BIND;
    end else if (job_start) begin
      job_valid_q <= 1'b1;
      job_frame_q <= s_axis_tuser || reply;
      step_q      <= s_axis_tuser ? STEP_FIRST : STEP_BIND;
    end else if (gen_fire) begin
      if (job_final) begin
        job_valid_q <= 1'b0;
      end else begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (job_start) begin
      desc_q     <= desc_d;
      bind_mac_q <= sender_mac_d;
      bind_ip_q  <= sender_ip_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_fire) begin
      out_tdata_q <= out_tdata_d;
      out_tlast_q <= out_tlast_d;
      out_tuser_q <= out_tuser_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tlast  = out_tlast_q;
  assign m_axis_tuser  = out_tuser_q;

`ifndef SYNTHESIS
  // A running job never steps past its final beat.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (step_q <= STEP_FINAL))
    else $error("job step out of range");

  // A frame end or resolve item always leaves a job running.
  a_job_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_start |=> job_valid_q)
    else $error("job not loaded");

  // A binding result carries no transmit bytes.
  a_bind_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[71:0] == 72'h0 && !m_axis_tlast))
    else $error("binding result carries transmit data");

  // The final frame beat also ends the run.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[152])
    else $error("frame end without run end");
`endif

endmodule

[tb/sv/arp_frame_responder_unit_checker.sv]
// Checker for the ARP responder: predicts every result beat and compares it with the output.
`timescale 1ns / 1ps

module arp_frame_responder_unit_checker
  import arpfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // rx_data[63:0], resolve_ip[95:64]
  input  logic                 s_axis_tlast,   // rx_last
  input  logic                 s_axis_tuser,   // kind
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tx_data[63:0], tx_keep[71:64], bind_mac[119:72], bind_ip[151:120], run_last[152], zero pad
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 m_axis_tlast,   // tx_frame_last
  input  logic                 m_axis_tuser,   // out_kind
  output int                   pending_o,
  output int                   fail_count_o
);

  // Result kinds.
  localparam logic OUT_TX       = 1'b0;
  localparam logic OUT_BIND     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
    logic [7:0]  keep;
    logic        frame_last;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        run_last;
    logic [6:0]  pad;
  } arp_result_t;

  arp_result_t expected_q[$];
  int          mismatches = 0;

  // Our addresses as last written.
  logic [47:0] own_mac;
  logic [31:0] own_ip;

  // Header fields captured from the received frames.
  logic [2:0]  beat_idx;
  logic [47:0] remote_mac;
  logic [15:0] rx_etype;
  logic [15:0] rx_htype;
  logic [15:0] rx_ptype;
  logic [7:0]  rx_hlen;
  logic [7:0]  rx_plen;
  logic [15:0] rx_oper;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;

  assign fail_count_o = mismatches;

  // Value of n bytes of a beat from byte s on, first byte most significant.
  function automatic logic [63:0] net_field(logic [63:0] beat, int s, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[55:0], beat[8*(s+i) +: 8]};
    return v;
  endfunction

  // Writes a field into a 48-byte frame in network order; frame byte k sits at bits 8k+7:8k.
  function automatic logic [383:0] place(logic [383:0] f, int s, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) f[8*(s+i) +: 8] = v[8*(n-1-i) +: 8];
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Six transmit beats of one frame.
  task automatic queue_frame(logic [383:0] f);
    arp_result_t r;
    for (int b = 0; b < 6; b++) begin
      r            = '0;
      r.kind       = OUT_TX;
      r.data       = f[64*b +: 64];
      r.keep       = (b == 5) ? KEEP_LAST_BEAT : KEEP_FULL;
      r.frame_last = (b == 5);
      r.run_last   = (b == 5);
      expected_q.push_back(r);
    end
  endtask

  // Updates the captured fields with one accepted beat and queues what it causes.
  task automatic predict_beat(logic kind, logic [63:0] d, logic last, logic [31:0] rip);
    logic [383:0] f;
    arp_result_t  r;
    logic         answer;
    f = '0;
    if (kind == KIND_RESOLVE) begin
      f = place(f, 0, 6, 64'(MAC_BCAST));
      f = place(f, 6, 6, 64'(own_mac));
      f = place(f, 12, 2, 64'(ETYPE_ARP));
      f = place(f, 14, 2, 64'(HTYPE_ETH));
      f = place(f, 16, 2, 64'(PTYPE_IPV4));
      f = place(f, 18, 1, 64'(HLEN_ETH));
      f = place(f, 19, 1, 64'(PLEN_IPV4));
      f = place(f, 20, 2, 64'(OPER_REQUEST));
      f = place(f, 22, 6, 64'(own_mac));
      f = place(f, 28, 4, 64'(own_ip));
      f = place(f, 38, 4, 64'(rip));
      queue_frame(f);
      return;
    end

    case (beat_idx)
      3'd0: remote_mac[47:32] = 16'(net_field(d, 6, 2));
      3'd1: begin
        remote_mac[31:0] = 32'(net_field(d, 0, 4));
        rx_etype         = 16'(net_field(d, 4, 2));
        rx_htype         = 16'(net_field(d, 6, 2));
      end
      3'd2: begin
        rx_ptype          = 16'(net_field(d, 0, 2));
        rx_hlen           = 8'(net_field(d, 2, 1));
        rx_plen           = 8'(net_field(d, 3, 1));
        rx_oper           = 16'(net_field(d, 4, 2));
        sender_mac[47:32] = 16'(net_field(d, 6, 2));
      end
      3'd3: begin
        sender_mac[31:0] = 32'(net_field(d, 0, 4));
        sender_ip        = 32'(net_field(d, 4, 4));
      end
      3'd4: target_ip[31:16] = 16'(net_field(d, 6, 2));
      3'd5: target_ip[15:0]  = 16'(net_field(d, 0, 2));
      default: ;
    endcase

    if (!last) begin
      if (beat_idx < BEAT_SAT) beat_idx++;
      return;
    end
    beat_idx = '0;

    // The binding always comes first; a request for our address adds a reply.
    answer     = (rx_oper == OPER_REQUEST) && (target_ip == own_ip);
    r          = '0;
    r.kind     = OUT_BIND;
    r.mac      = sender_mac;
    r.ip       = sender_ip;
    r.run_last = !answer;
    expected_q.push_back(r);
    if (!answer) return;

    f = place(f, 0, 6, 64'(remote_mac));
    f = place(f, 6, 6, 64'(own_mac));
    f = place(f, 12, 2, 64'(rx_etype));
    f = place(f, 14, 2, 64'(rx_htype));
    f = place(f, 16, 2, 64'(rx_ptype));
    f = place(f, 18, 1, 64'(rx_hlen));
    f = place(f, 19, 1, 64'(rx_plen));
    f = place(f, 20, 2, 64'(OPER_REPLY));
    f = place(f, 22, 6, 64'(own_mac));
    f = place(f, 28, 4, 64'(own_ip));
    f = place(f, 32, 6, 64'(sender_mac));
    f = place(f, 38, 4, 64'(sender_ip));
    queue_frame(f);
  endtask

  // Compares one output beat with the oldest expected result.
  task automatic check_result(arp_result_t got);
    arp_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result beat, tx_data", got.data, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind != want.kind) report_mismatch("out_kind", 64'(got.kind), 64'(want.kind));
    if (got.data != want.data) report_mismatch("tx_data", got.data, want.data);
    if (got.keep != want.keep) report_mismatch("tx_keep", 64'(got.keep), 64'(want.keep));
    if (got.frame_last != want.frame_last)
      report_mismatch("tx_frame_last", 64'(got.frame_last), 64'(want.frame_last));
    if (got.mac != want.mac) report_mismatch("bind_mac", 64'(got.mac), 64'(want.mac));
    if (got.ip != want.ip) report_mismatch("bind_ip", 64'(got.ip), 64'(want.ip));
    if (got.run_last != want.run_last)
      report_mismatch("run_last", 64'(got.run_last), 64'(want.run_last));
    if (got.pad != want.pad) report_mismatch("tdata pad", 64'(got.pad), 64'(want.pad));
  endtask

  // Register writes, then the output beat, then the input beat of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac    = '0;
      own_ip     = '0;
      beat_idx   = '0;
      remote_mac = '0;
      rx_etype   = '0;
      rx_htype   = '0;
      rx_ptype   = '0;
      rx_hlen    = '0;
      rx_plen    = '0;
      rx_oper    = '0;
      sender_mac = '0;
      sender_ip  = '0;
      target_ip  = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_MY_MAC) own_mac = cfg_wdata_i[47:0];
        else if (cfg_addr_i == REG_MY_IP) own_ip = cfg_wdata_i[31:0];
      end
      if (m_axis_tvalid && m_axis_tready)
        check_result({m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[71:64], m_axis_tlast,
                      m_axis_tdata[119:72], m_axis_tdata[151:120], m_axis_tdata[152],
                      m_axis_tdata[159:153]});
      if (s_axis_tvalid && s_axis_tready)
        predict_beat(s_axis_tuser, s_axis_tdata[63:0], s_axis_tlast, s_axis_tdata[95:64]);
      pending_o <= expected_q.size();
    end
  end

endmodule

[tb/sv/arp_frame_responder_unit_tb.sv]
// Testbench top for the ARP responder: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module arp_frame_responder_unit_tb;
  import arpfr_pkg::*;

  localparam int   IDLE_PCT     = 31;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;

  int          pending;
  int          fails;
  int          beats_sent;
  logic        steady;
  logic [47:0] cur_mac;
  logic [31:0] cur_ip;

  arp_frame_responder_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  arp_frame_responder_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Writes a field into a frame image in network order; frame byte k at bits 8k+7:8k.
  function automatic logic [767:0] put_bytes(logic [767:0] f, int s, int n, logic [63:0] v);
    for (int i = 0; i < n; i++) f[8*(s+i) +: 8] = v[8*(n-1-i) +: 8];
    return f;
  endfunction

  // Random frame image of twelve beats; with std_hdr the header is a proper ARP header.
  function automatic logic [767:0] arp_frame(logic [15:0] oper, logic [31:0] tpa, bit std_hdr);
    logic [767:0] f;
    for (int w = 0; w < 24; w++) f[32*w +: 32] = $urandom;
    if ($urandom_range(0, 1)) f = put_bytes(f, 0, 6, 64'(cur_mac));
    if (std_hdr) begin
      f = put_bytes(f, 12, 2, 64'(ETYPE_ARP));
      f = put_bytes(f, 14, 2, 64'(HTYPE_ETH));
      f = put_bytes(f, 16, 2, 64'(PTYPE_IPV4));
      f = put_bytes(f, 18, 1, 64'(HLEN_ETH));
      f = put_bytes(f, 19, 1, 64'(PLEN_IPV4));
    end
    f = put_bytes(f, 20, 2, 64'(oper));
    f = put_bytes(f, 38, 4, 64'(tpa));
    return f;
  endfunction

  // Offers one beat after an optional random gap and waits until it is taken.
  task automatic send_item(logic kind, logic [63:0] data, logic last, logic [31:0] rip);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rip, data};
    s_axis_tlast  <= last;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_resolve(logic [31:0] ip);
    send_item(KIND_RESOLVE, {$urandom, $urandom}, 1'($urandom_range(0, 1)), ip);
  endtask

  // Sends the first beats of a frame image, now and then with a resolve item in between.
  task automatic send_frame(logic [767:0] f, int beats);
    for (int b = 0; b < beats; b++) begin
      if ($urandom_range(0, 99) < 3) send_resolve($urandom);
      send_item(KIND_FRAME, f[64*b +: 64], b == beats - 1, $urandom);
    end
  endtask

  // Stops offering beats until every expected result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Writes both address registers; only called while the block is idle.
  task automatic load_addresses(logic [47:0] mac, logic [31:0] ip);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_MY_MAC;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cfg_addr_i  <= REG_MY_IP;
    cfg_wdata_i <= CFG_W'(ip);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mac = mac;
    cur_ip  = ip;
  endtask

  // Mostly proper ARP frames of random content, with resolve items and noise frames.
  task automatic random_phase(int quota);
    int          first;
    int          pick;
    int          beats;
    logic [15:0] oper;
    logic [31:0] tpa;
    first = beats_sent;
    while (beats_sent - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        wait_drained();
      end else if (pick < 13) begin
        send_resolve($urandom);
      end else if (pick < 23) begin
        send_frame(arp_frame(16'($urandom), $urandom, 1'b0), $urandom_range(1, 10));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) beats = 6;
        else if (pick < 8) beats = $urandom_range(7, 9);
        else beats = $urandom_range(1, 5);
        if ($urandom_range(0, 3) != 0) oper = OPER_REQUEST;
        else if ($urandom_range(0, 1)) oper = OPER_REPLY;
        else oper = 16'($urandom);
        tpa = $urandom_range(0, 1) ? cur_ip : 32'($urandom);
        send_frame(arp_frame(oper, tpa, $urandom_range(0, 4) != 0), beats);
      end
    end
  endtask

  // Finishes a phase so that the registers can be written again.
  task automatic settle();
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= REG_MY_MAC;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= KIND_FRAME;
    steady        <= 1'b0;
    beats_sent    = 0;
    cur_mac       = '0;
    cur_ip        = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: resolve extremes, a request for us, a plain reply, long and short frames.
    load_addresses(48'({$urandom, $urandom}), $urandom);
    send_resolve('0);
    send_resolve('1);
    send_frame(arp_frame(OPER_REQUEST, cur_ip, 1'b1), 6);
    send_frame(arp_frame(OPER_REPLY, cur_ip, 1'b1), 6);
    send_frame(arp_frame(OPER_REQUEST, ~cur_ip, 1'b1), 8);
    // A short frame keeps the target address of the long frame before it.
    send_frame(arp_frame(OPER_REQUEST, cur_ip, 1'b1), 3);
    send_item(KIND_FRAME, '1, 1'b1, '1);
    send_item(KIND_FRAME, '0, 1'b1, '0);
    settle();

    // Random part over several address settings, the extremes among them.
    load_addresses('0, '0);
    random_phase(85);
    settle();
    load_addresses('1, '1);
    steady <= 1'b1;
    random_phase(85);
    steady <= 1'b0;
    settle();
    load_addresses(48'({$urandom, $urandom}), $urandom);
    random_phase(85);
    settle();
    load_addresses(48'({$urandom, $urandom}), $urandom);
    random_phase(85);
    settle();
    load_addresses(48'({$urandom, $urandom}), $urandom);
    random_phase(85);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
